FILE: sv/mis_pkg.sv
// Shared types and constants for the maximum independent set search block.
package mis_pkg;

    localparam int unsigned MaxNodes = 64;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_EDGE  = 2'd1,
        KIND_SOLVE = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_WA,
        ST_EDGE_WB,
        ST_INIT,
        ST_EXPAND,
        ST_BACK,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load_start;
        logic load_edge;
        logic edge_rd;
        logic edge_wr_a;
        logic edge_wr_b;
        logic init;
        logic expand;
        logic leaf;
        logic back;
        logic emit_load;
        logic emit_step;
    } cmd_t;

    // Datapath status to the controller.
    typedef struct packed {
        logic cand_empty;
        logic prune;
        logic stack_empty;
        logic best_zero;
        logic emit_done;
    } status_t;

endpackage

FILE: sv/mis_stream_if.sv
// Valid/ready channel interface with a generic payload.
interface mis_stream_if #(
    parameter int unsigned W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/max_independent_set_search.sv
// Top level of the maximum independent set search block.
//
//  channel  direction  payload
//  in       sink       kind, node_count, end_a, end_b
//  out      source     set_size, member, last
//
// Start items and unused kinds are handled on acceptance; edge items go through
// accept, row read and the row writes of both ends. A solve visits each search
// node with a row read, then an expand or test, takes a return step for each saved
// exclude branch and a finish step; visits can grow exponentially with the node number.
// Results then go out in turn; out stalls hold the result in place. Reset clears
// registers, not RAMs, asynchronously; in.ready is low until a solve's last transfer.
module max_independent_set_search #(
    parameter int unsigned MAX_NODES = mis_pkg::MaxNodes
) (
    input logic          clk,
    input logic          rst_n,
    mis_stream_if.sink   in,
    mis_stream_if.source out
);
    mis_pkg::cmd_t    cmd;
    mis_pkg::status_t status;
    logic             out_valid_c;

    logic [1:0] kind;
    logic [6:0] node_count, end_a, end_b, set_size, member;
    logic       last;

    assign kind       = in.payload[22:21];
    assign node_count = in.payload[20:14];
    assign end_a      = in.payload[13:7];
    assign end_b      = in.payload[6:0];

    mis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .in_kind   (kind),
        .out_ready (out.ready),
        .out_valid (out_valid_c),
        .cmd       (cmd),
        .status    (status)
    );

    mis_dp #(.MAX_NODES(MAX_NODES)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_node_count (node_count),
        .in_end_a      (end_a),
        .in_end_b      (end_b),
        .set_size      (set_size),
        .member        (member),
        .last          (last)
    );

    assign out.valid   = out_valid_c;
    assign out.payload = {set_size, member, last};
endmodule

FILE: sv/mis_ram.sv
// Generic RAM with one write port and one registered read port.
module mis_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/mis_ctrl.sv
// Controller state machine for the search.
module mis_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_kind,
    input  logic              out_ready,
    output logic              out_valid,
    output mis_pkg::cmd_t     cmd,
    input  mis_pkg::status_t  status
);
    mis_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mis_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            mis_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_kind)
                        mis_pkg::KIND_START: cmd.load_start = 1'b1;
                        mis_pkg::KIND_EDGE:
                        begin
                            cmd.load_edge = 1'b1;
                            state_next    = mis_pkg::ST_EDGE_RD;
                        end
                        mis_pkg::KIND_SOLVE:
                        begin
                            cmd.init   = 1'b1;
                            state_next = mis_pkg::ST_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            mis_pkg::ST_EDGE_RD:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = mis_pkg::ST_EDGE_WA;
            end
            mis_pkg::ST_EDGE_WA:
            begin
                cmd.edge_wr_a = 1'b1;
                state_next    = mis_pkg::ST_EDGE_WB;
            end
            mis_pkg::ST_EDGE_WB:
            begin
                cmd.edge_wr_b = 1'b1;
                state_next    = mis_pkg::ST_IDLE;
            end
            mis_pkg::ST_INIT:
            begin
                state_next = mis_pkg::ST_EXPAND;
            end
            mis_pkg::ST_EXPAND:
            begin
                if (status.cand_empty)
                begin
                    cmd.leaf   = 1'b1;
                    state_next = mis_pkg::ST_BACK;
                end
                else if (status.prune)
                begin
                    state_next = mis_pkg::ST_BACK;
                end
                else
                begin
                    cmd.expand = 1'b1;
                    state_next = mis_pkg::ST_INIT;
                end
            end
            mis_pkg::ST_BACK:
            begin
                if (status.stack_empty)
                begin
                    cmd.emit_load = 1'b1;
                    state_next = status.best_zero ? mis_pkg::ST_EMPTY : mis_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.back   = 1'b1;
                    state_next = mis_pkg::ST_INIT;
                end
            end
            mis_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.emit_step = 1'b1;
                    if (status.emit_done)
                    begin
                        state_next = mis_pkg::ST_IDLE;
                    end
                end
            end
            mis_pkg::ST_EMPTY:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = mis_pkg::ST_IDLE;
                end
            end
            default: state_next = mis_pkg::ST_IDLE;
        endcase
    end
endmodule

FILE: sv/mis_dp.sv
// Datapath: adjacency memory, search stack memory and result emitter.
module mis_dp #(
    parameter int unsigned MAX_NODES = mis_pkg::MaxNodes
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mis_pkg::cmd_t     cmd,
    output mis_pkg::status_t  status,
    input  logic [6:0]        in_node_count,
    input  logic [6:0]        in_end_a,
    input  logic [6:0]        in_end_b,
    output logic [6:0]        set_size,
    output logic [6:0]        member,
    output logic              last
);
    localparam int unsigned N  = MAX_NODES;
    localparam int unsigned AW = (N > 1) ? $clog2(N) : 1;
    localparam int unsigned DW = $clog2(N + 1);
    localparam int unsigned RD = 1 << AW;
    localparam int unsigned PW = 8 * ((N + 7) / 8);

    // Saved frame for a pending exclude branch.
    typedef struct packed {
        logic [N-1:0]  chosen;
        logic [DW-1:0] count;
        logic [N-1:0]  cand;
    } frame_t;

    localparam int unsigned FW = $bits(frame_t);

    logic [6:0]    nodes_reg;
    logic [N-1:0]  valid_row_reg;
    logic [AW-1:0] ea_reg, eb_reg;
    logic          edge_ok_reg;
    logic [N-1:0]  chosen_reg, cand_reg, best_reg, emit_mask_reg;
    logic [DW-1:0] count_reg, best_cnt_reg, sp_reg, cand_pop_reg;

    // Population count in byte groups.
    function automatic logic [DW-1:0] pop_count(input logic [N-1:0] v);
        logic [PW-1:0] padded;
        logic [3:0]    part;
        logic [DW-1:0] total;
        padded = PW'(v);
        total  = '0;
        for (int g = 0; g < PW / 8; g++)
        begin
            part = '0;
            for (int k = 0; k < 8; k++)
            begin
                part = part + 4'(padded[8 * g + k]);
            end
            total = total + DW'(part);
        end
        return total;
    endfunction

    // Adjacency rows live in RAM; rows not written since the last start read as zero.
    logic          adj_we;
    logic [AW-1:0] adj_waddr, adj_raddr;
    logic [N-1:0]  adj_wdata, adj_rdata, adj_row;

    mis_ram #(.WIDTH(N), .DEPTH(RD)) u_adj (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // Exclude frames are kept in a stack RAM whose top is read ahead.
    logic          stk_we;
    logic [AW-1:0] stk_waddr, stk_raddr;
    logic [FW-1:0] stk_wdata, stk_rdata;
    frame_t        top_frame;

    mis_ram #(.WIDTH(FW), .DEPTH(RD)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Lowest open candidate, its bit and its open neighbours.
    logic [AW-1:0] low_idx;
    logic [N-1:0]  low_bit, rest, nb;
    logic          nb_many;
    always_comb
    begin
        low_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (cand_reg[i])
            begin
                low_idx = AW'(i);
            end
        end
        low_bit = cand_reg & (~cand_reg + N'(1));
        rest    = cand_reg & ~low_bit;
    end

    assign adj_row = valid_row_reg[low_idx] ? adj_rdata : '0;
    assign nb      = adj_row & rest;
    assign nb_many = |(nb & (nb - N'(1)));

    // Item decoding.
    logic         edge_ok;
    logic [6:0]   n_sat;
    logic [N-1:0] all_mask;
    assign edge_ok  = (in_end_a != in_end_b) && (in_end_a != 7'd0) && (in_end_b != 7'd0)
                      && (in_end_a <= nodes_reg) && (in_end_b <= nodes_reg);
    assign n_sat    = (in_node_count > 7'(N)) ? 7'(N) : in_node_count;
    assign all_mask = (nodes_reg >= 7'(N)) ? '1 : N'((N'(1) << nodes_reg) - N'(1));

    // Adjacency port use: search reads, or an edge read-modify-write of both rows.
    always_comb
    begin
        adj_we    = 1'b0;
        adj_waddr = ea_reg;
        adj_wdata = (valid_row_reg[ea_reg] ? adj_rdata : '0) | (N'(1) << eb_reg);
        adj_raddr = low_idx;
        if (cmd.edge_rd)
        begin
            adj_raddr = ea_reg;
        end
        if (cmd.edge_wr_a)
        begin
            adj_we    = edge_ok_reg;
            adj_raddr = eb_reg;
        end
        if (cmd.edge_wr_b)
        begin
            adj_we    = edge_ok_reg;
            adj_waddr = eb_reg;
            adj_wdata = (valid_row_reg[eb_reg] ? adj_rdata : '0) | (N'(1) << ea_reg);
        end
    end

    // Stack push on an expand that leaves an exclude branch worth trying.
    assign stk_we    = cmd.expand && nb_many;
    assign stk_waddr = AW'(sp_reg);
    assign stk_wdata = {chosen_reg, count_reg, rest};
    assign stk_raddr = AW'(sp_reg - DW'(1));
    assign top_frame = frame_t'(stk_rdata);

    assign status.cand_empty  = (cand_reg == '0);
    assign status.prune       = ({1'b0, count_reg} + {1'b0, cand_pop_reg}) <= {1'b0, best_cnt_reg};
    assign status.stack_empty = (sp_reg == '0);
    assign status.best_zero   = (best_cnt_reg == '0);
    assign status.emit_done   = ((emit_mask_reg & (emit_mask_reg - N'(1))) == '0);

    // Lowest remaining member of the emitted set.
    logic [AW-1:0] emit_idx;
    always_comb
    begin
        emit_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (emit_mask_reg[i])
            begin
                emit_idx = AW'(i);
            end
        end
    end

    assign set_size = 7'(best_cnt_reg);
    assign member   = status.best_zero ? 7'd0 : 7'(emit_idx) + 7'd1;
    assign last     = status.best_zero ? 1'b1 : status.emit_done;

    // Graph, search and emitter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_reg     <= '0;
            valid_row_reg <= '0;
            ea_reg        <= '0;
            eb_reg        <= '0;
            edge_ok_reg   <= 1'b0;
            chosen_reg    <= '0;
            cand_reg      <= '0;
            best_reg      <= '0;
            emit_mask_reg <= '0;
            count_reg     <= '0;
            best_cnt_reg  <= '0;
            sp_reg        <= '0;
            cand_pop_reg  <= '0;
        end
        else
        begin
            cand_pop_reg <= pop_count(cand_reg);
            if (cmd.load_start)
            begin
                nodes_reg     <= n_sat;
                valid_row_reg <= '0;
            end
            else if (cmd.load_edge)
            begin
                ea_reg      <= AW'(in_end_a - 7'd1);
                eb_reg      <= AW'(in_end_b - 7'd1);
                edge_ok_reg <= edge_ok;
            end
            else if (cmd.edge_wr_a)
            begin
                if (edge_ok_reg)
                begin
                    valid_row_reg[ea_reg] <= 1'b1;
                end
            end
            else if (cmd.edge_wr_b)
            begin
                if (edge_ok_reg)
                begin
                    valid_row_reg[eb_reg] <= 1'b1;
                end
            end
            else if (cmd.init)
            begin
                chosen_reg   <= '0;
                count_reg    <= '0;
                cand_reg     <= all_mask;
                best_reg     <= '0;
                best_cnt_reg <= '0;
                sp_reg       <= '0;
            end
            else if (cmd.expand)
            begin
                if (nb_many)
                begin
                    sp_reg <= sp_reg + DW'(1);
                end
                chosen_reg <= chosen_reg | low_bit;
                count_reg  <= count_reg + DW'(1);
                cand_reg   <= rest & ~nb;
            end
            else if (cmd.leaf)
            begin
                if (count_reg > best_cnt_reg)
                begin
                    best_cnt_reg <= count_reg;
                    best_reg     <= chosen_reg;
                end
            end
            else if (cmd.back)
            begin
                sp_reg     <= sp_reg - DW'(1);
                chosen_reg <= top_frame.chosen;
                count_reg  <= top_frame.count;
                cand_reg   <= top_frame.cand;
            end
            else if (cmd.emit_load)
            begin
                emit_mask_reg <= best_reg;
            end
            else if (cmd.emit_step)
            begin
                emit_mask_reg <= emit_mask_reg & (emit_mask_reg - N'(1));
            end
        end
    end
endmodule

FILE: sv/mis_checker.sv
// Port-level checks for the search block, bound to the top level.
module mis_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [14:0] out_payload
);
    // No input is taken while a result is offered.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken during output");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result changed under stall");

    // A set size of zero is always a single final result.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload[14:8] == 7'd0 |-> out_payload[0])
        else $error("empty set not marked last");
endmodule

bind max_independent_set_search mis_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in.valid),
    .in_ready    (in.ready),
    .out_valid   (out.valid),
    .out_ready   (out.ready),
    .out_payload (out.payload)
);

FILE: tb/testbench.sv
// Self-checking testbench for the maximum independent set search block.
module testbench;

    // One input transfer and one result transfer.
    typedef struct packed {
        bit [1:0] kind;
        bit [6:0] node_count;
        bit [6:0] end_a;
        bit [6:0] end_b;
    } graph_cmd_t;

    typedef struct packed {
        bit [6:0] set_size;
        bit [6:0] member;
        bit       last;
    } set_member_t;

    logic clk;
    logic rst_n;

    mis_stream_if #(.W(23)) cmd_ch ();
    mis_stream_if #(.W(15)) res_ch ();

    max_independent_set_search dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (cmd_ch),
        .out   (res_ch)
    );

    graph_cmd_t  pending_cmds[$];
    set_member_t expected_members[$];
    bit          failed;
    int unsigned solve_count;
    int unsigned member_count;
    int unsigned largest_set;

    // Shadow copy of the graph and of the best set found.
    bit [63:0]   shadow_adj[64];
    int unsigned shadow_nodes;
    bit [63:0]   top_mask;
    int unsigned top_count;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Depth-first search: include before exclude, prune hopeless branches.
    function automatic void search_set(bit [63:0] chosen, int unsigned cnt, bit [63:0] cand);
        int unsigned v;
        bit [63:0]   nbit;
        bit [63:0]   rest;
        bit [63:0]   nb;
        if (cand == 64'd0)
        begin
            if (cnt > top_count)
            begin
                top_count = cnt;
                top_mask  = chosen;
            end
            return;
        end
        if (cnt + $countones(cand) <= top_count)
            return;
        v = 0;
        while (v < 63 && cand[v] == 1'b0)
            v++;
        nbit = 64'd1 << v;
        rest = cand & ~nbit;
        nb   = shadow_adj[v] & rest;
        search_set(chosen | nbit, cnt + 1, rest & ~nb);
        // Excluding a node with at most one open neighbour cannot win.
        if ($countones(nb) <= 1)
            return;
        search_set(chosen, cnt, rest);
    endfunction

    // Update the shadow graph and queue the results an accepted command causes.
    function automatic void predict_cmd(graph_cmd_t c);
        int unsigned emitted;
        bit [63:0]   all_mask;
        case (c.kind)
            mis_pkg::KIND_START:
            begin
                foreach (shadow_adj[i])
                    shadow_adj[i] = 64'd0;
                shadow_nodes = (c.node_count > mis_pkg::MaxNodes) ? mis_pkg::MaxNodes
                                                                  : c.node_count;
            end
            mis_pkg::KIND_EDGE:
            begin
                if (c.end_a != c.end_b && c.end_a >= 1 && c.end_b >= 1 &&
                    c.end_a <= shadow_nodes && c.end_b <= shadow_nodes)
                begin
                    shadow_adj[c.end_a - 1][c.end_b - 1] = 1'b1;
                    shadow_adj[c.end_b - 1][c.end_a - 1] = 1'b1;
                end
            end
            mis_pkg::KIND_SOLVE:
            begin
                solve_count++;
                top_count = 0;
                top_mask  = 64'd0;
                all_mask  = (shadow_nodes >= 64) ? '1 : ((64'd1 << shadow_nodes) - 1);
                search_set(64'd0, 0, all_mask);
                if (top_count > largest_set)
                    largest_set = top_count;
                if (top_count == 0)
                    expected_members.insert(expected_members.size(), '{7'd0, 7'd0, 1'b1});
                else
                begin
                    emitted = 0;
                    for (int i = 0; i < 64; i++)
                    begin
                        if (top_mask[i])
                        begin
                            emitted++;
                            expected_members.insert(expected_members.size(),
                                                    '{top_count[6:0], 7'(i + 1),
                                                      emitted == top_count});
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        logic       next_valid;
        graph_cmd_t next_cmd;
        if (!rst_n)
        begin
            cmd_ch.valid   <= 1'b0;
            cmd_ch.payload <= '0;
            burst_left     = 4;
            gap_left       = 0;
        end
        else
        begin
            next_valid = cmd_ch.valid;
            next_cmd   = cmd_ch.payload;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                predict_cmd(pending_cmds.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 10);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    next_valid = 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    next_valid = 1'b1;
                    next_cmd   = pending_cmds[0];
                end
                else
                    next_valid = 1'b0;
            end
            cmd_ch.valid   <= next_valid;
            cmd_ch.payload <= next_cmd;
        end
    end

    // Receiver: stall pattern in one of four modes, redrawn at random when a mode counter expires.
    int unsigned stall_mode;
    int unsigned mode_cycles;
    int unsigned phase;

    always @(posedge clk or negedge rst_n)
    begin
        set_member_t got;
        set_member_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_mode  = 0;
            mode_cycles = 0;
            phase       = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got = res_ch.payload;
                member_count++;
                if (expected_members.size() == 0)
                begin
                    $error("result with no expectation: set_size %0d member %0d last %0d",
                           got.set_size, got.member, got.last);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_members.pop_front();
                    if (got.set_size != want.set_size)
                    begin
                        $error("set_size: expected %0d, got %0d", want.set_size, got.set_size);
                        failed = 1'b1;
                    end
                    if (got.member != want.member)
                    begin
                        $error("member: expected %0d, got %0d", want.member, got.member);
                        failed = 1'b1;
                    end
                    if (got.last != want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        failed = 1'b1;
                    end
                end
            end
            mode_cycles++;
            if (mode_cycles >= 300)
            begin
                mode_cycles = 0;
                stall_mode  = $urandom_range(0, 3);
            end
            phase++;
            case (stall_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= phase[0];
                2: res_ch.ready <= (phase % 7) > 3;
                default: res_ch.ready <= ($urandom_range(0, 9) > 2);
            endcase
        end
    end

    task automatic add_cmd(mis_pkg::kind_t k, int unsigned nc, int unsigned a, int unsigned b);
        pending_cmds.insert(pending_cmds.size(), '{k, nc[6:0], a[6:0], b[6:0]});
    endtask

    // A small random graph, possibly with stray edges, then a solve.
    task automatic add_small_graph();
        int unsigned n;
        int unsigned edges;
        n = $urandom_range(1, 14);
        add_cmd(mis_pkg::KIND_START, n, $urandom_range(0, 127), $urandom_range(0, 127));
        edges = $urandom_range(0, 2 * n);
        repeat (edges)
        begin
            if ($urandom_range(0, 9) == 0)
                add_cmd(mis_pkg::KIND_EDGE, $urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 127));
            else
                add_cmd(mis_pkg::KIND_EDGE, $urandom_range(0, 127), $urandom_range(1, n),
                        $urandom_range(1, n));
        end
        add_cmd(mis_pkg::KIND_SOLVE, $urandom_range(0, 127), $urandom_range(0, 127),
                $urandom_range(0, 127));
    endtask

    // A large forest: each node has at most one higher neighbour, so the search stays short.
    task automatic add_large_forest();
        int unsigned n;
        n = $urandom_range(40, 100);
        add_cmd(mis_pkg::KIND_START, n, 0, 0);
        if (n > mis_pkg::MaxNodes)
            n = mis_pkg::MaxNodes;
        for (int unsigned v = 1; v < n; v++)
        begin
            if ($urandom_range(0, 2) != 0)
                add_cmd(mis_pkg::KIND_EDGE, 0, v, $urandom_range(v + 1, n));
        end
        add_cmd(mis_pkg::KIND_EDGE, 0, 5, 5);
        add_cmd(mis_pkg::KIND_EDGE, 0, n + 1, 1);
        add_cmd(mis_pkg::KIND_SOLVE, 0, 0, 0);
    endtask

    initial
    begin
        failed       = 1'b0;
        solve_count  = 0;
        member_count = 0;
        largest_set  = 0;
        shadow_nodes = 0;
        foreach (shadow_adj[i])
            shadow_adj[i] = 64'd0;

        // Directed part: empty graph after reset, saturated count, ignored edges, kind 3.
        add_cmd(mis_pkg::KIND_SOLVE, 0, 0, 0);
        add_cmd(mis_pkg::KIND_START, 0, 0, 0);
        add_cmd(mis_pkg::KIND_SOLVE, 127, 127, 127);
        add_cmd(mis_pkg::KIND_START, 127, 0, 0);
        add_cmd(mis_pkg::KIND_SOLVE, 0, 0, 0);
        add_cmd(mis_pkg::KIND_START, 64, 0, 0);
        add_cmd(mis_pkg::KIND_EDGE, 0, 1, 64);
        add_cmd(mis_pkg::KIND_EDGE, 0, 64, 63);
        add_cmd(mis_pkg::KIND_SOLVE, 0, 0, 0);
        add_cmd(mis_pkg::KIND_START, 4, 0, 0);
        add_cmd(mis_pkg::KIND_EDGE, 0, 2, 2);
        add_cmd(mis_pkg::KIND_EDGE, 0, 0, 1);
        add_cmd(mis_pkg::KIND_EDGE, 0, 1, 5);
        add_cmd(mis_pkg::KIND_EDGE, 0, 127, 127);
        add_cmd(mis_pkg::KIND_EDGE, 0, 1, 2);
        add_cmd(mis_pkg::KIND_EDGE, 0, 3, 2);
        add_cmd(mis_pkg::KIND_NONE, 127, 127, 127);
        add_cmd(mis_pkg::KIND_SOLVE, 0, 0, 0);
        add_cmd(mis_pkg::KIND_SOLVE, 0, 0, 0);

        // Random part: mostly well-formed graphs, some noise.
        while (pending_cmds.size() < 370)
        begin
            case ($urandom_range(0, 19))
                0:       add_large_forest();
                1:       add_cmd(mis_pkg::KIND_NONE, $urandom_range(0, 127),
                                 $urandom_range(0, 127), $urandom_range(0, 127));
                2:       add_cmd(mis_pkg::KIND_SOLVE, 0, 0, 0);
                3:       add_cmd(mis_pkg::KIND_EDGE, 0, $urandom_range(0, 127),
                                 $urandom_range(0, 127));
                default: add_small_graph();
            endcase
        end

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_cmds.size() == 0);
        @(posedge clk);
        wait (!cmd_ch.valid && expected_members.size() == 0);
        repeat (200) @(posedge clk);
        if (expected_members.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_members.size());
            failed = 1'b1;
        end

        $display("Ran %0d solves over random and directed graphs, checked %0d members.",
                 solve_count, member_count);
        $display("Largest independent set seen: %0d nodes.", largest_set);
        if (!failed)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog for a hung search or handshake.
    initial
    begin
        #1000000000;
        $display("Verification failed");
        $finish;
    end

endmodule
